/* src/sapc_pkg.sv */
// Shared types and constants for the stepper axis pulse controller.
package sapc_pkg;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_MOVE       = 3'd1,
      KIND_SET_TARGET = 3'd2,
      KIND_CONT_ON    = 3'd3,
      KIND_CONT_OFF   = 3'd4,
      KIND_STOP       = 3'd5,
      KIND_HOME       = 3'd6,
      KIND_CENTRE     = 3'd7
   } kind_type;

   localparam int SHIFT_WIDTH = 4;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = 4'd4;
   localparam int TARGET_WIDTH = 32;
   localparam int OUT_POS_WIDTH = 32;
   localparam longint HOME_STEPS = 100000;

   typedef struct packed {
      kind_type kind;
      logic     min_hit;
      logic     max_hit;
   } req_flags_type;

   typedef struct packed {
      logic                     step_level;
      logic                     direction_plus;
      logic                     moving;
      logic                     continuous_active;
      logic [OUT_POS_WIDTH-1:0] position;
      logic [OUT_POS_WIDTH-1:0] max_position;
   } rsp_item_type;

endpackage

/* src/sapc_if.sv */
// Request and response channel interfaces (valid/ready with payload).
interface sapc_req_if import sapc_pkg::*; #(parameter int STEP_WIDTH = 18) ();
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic [STEP_WIDTH-1:0]   move_steps;
   logic [TARGET_WIDTH-1:0] target_position;
   logic                    min_limit_hit;
   logic                    max_limit_hit;

   modport source (output valid, kind, move_steps, target_position, min_limit_hit,
                   max_limit_hit, input ready);
   modport sink (input valid, kind, move_steps, target_position, min_limit_hit,
                 max_limit_hit, output ready);
endinterface

interface sapc_rsp_if import sapc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     step_level;
   logic                     direction_plus;
   logic                     moving;
   logic                     continuous_active;
   logic [OUT_POS_WIDTH-1:0] position;
   logic [OUT_POS_WIDTH-1:0] max_position;

   modport source (output valid, step_level, direction_plus, moving, continuous_active,
                   position, max_position, input ready);
   modport sink (input valid, step_level, direction_plus, moving, continuous_active,
                 position, max_position, output ready);
endinterface

/* src/sapc_in_reg.sv */
// Input register stage: holds one accepted request until the core consumes it.
module sapc_in_reg import sapc_pkg::*; #(
   parameter int STEP_WIDTH = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   sapc_req_if.sink                req_ch,
   input  logic                    advance,
   output logic                    item_valid,
   output req_flags_type           flags,
   output logic [STEP_WIDTH-1:0]   move_steps,
   output logic [TARGET_WIDTH-1:0] target_position
);

   logic                    valid_ff;
   req_flags_type           flags_ff;
   logic [STEP_WIDTH-1:0]   steps_ff;
   logic [TARGET_WIDTH-1:0] target_ff;
   logic                    take;

   // refill in the same cycle the held item moves on
   assign req_ch.ready = !valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         flags_ff.kind    <= req_ch.kind;
         flags_ff.min_hit <= req_ch.min_limit_hit;
         flags_ff.max_hit <= req_ch.max_limit_hit;
         steps_ff         <= req_ch.move_steps;
         target_ff        <= req_ch.target_position;
      end
   end

   assign item_valid      = valid_ff;
   assign flags           = flags_ff;
   assign move_steps      = steps_ff;
   assign target_position = target_ff;

endmodule

/* src/sapc_move_calc.sv */
// Toggle count for a move, homing or centre command.
module sapc_move_calc import sapc_pkg::*; #(
   parameter int POSITION_WIDTH = 32,
   parameter int STEP_WIDTH = 18
) (
   input  kind_type                  kind,
   input  logic [STEP_WIDTH-1:0]     move_steps,
   input  logic [SHIFT_WIDTH-1:0]    shift,
   input  logic [POSITION_WIDTH-1:0] cur_pos,
   input  logic [POSITION_WIDTH-1:0] learned_max,
   output logic [POSITION_WIDTH-1:0] total
);

   // wide enough for any position plus a rounding bias of up to 2^17
   localparam int EW = POSITION_WIDTH + 18;
   localparam logic [63:0] HOME_64 = 64'(HOME_STEPS);

   logic [63:0]                steps_sx;
   logic [POSITION_WIDTH-1:0]  home_p;
   logic [POSITION_WIDTH-1:0]  steps_p;
   logic [4:0]                 k_here;
   logic [4:0]                 k_centre;
   logic signed [EW-1:0]       lm_e, cp_e;
   logic signed [EW-1:0]       mask_here, mask_centre;
   logic signed [EW-1:0]       lm_bias, cp_bias;
   logic signed [EW-1:0]       centre_e, here_e, diff_e;

   assign steps_sx = {{(64-STEP_WIDTH){move_steps[STEP_WIDTH-1]}}, move_steps};
   assign home_p   = HOME_64[POSITION_WIDTH-1:0];

   assign k_here   = {1'b0, shift} + 5'd1;
   assign k_centre = {1'b0, shift} + 5'd2;

   // divide toward zero: add 2^k-1 to negative values before the arithmetic shift
   assign lm_e        = EW'($signed(learned_max));
   assign cp_e        = EW'($signed(cur_pos));
   assign mask_centre = ~({EW{1'b1}} << k_centre);
   assign mask_here   = ~({EW{1'b1}} << k_here);
   assign lm_bias     = lm_e[EW-1] ? mask_centre : '0;
   assign cp_bias     = cp_e[EW-1] ? mask_here : '0;
   assign centre_e    = (lm_e + lm_bias) >>> k_centre;
   assign here_e      = (cp_e + cp_bias) >>> k_here;
   assign diff_e      = centre_e - here_e;

   always_comb begin
      case (kind)
         KIND_MOVE: begin
            steps_p = steps_sx[POSITION_WIDTH-1:0];
         end
         KIND_HOME: begin
            steps_p = move_steps[STEP_WIDTH-1] ? ('0 - home_p) : home_p;
         end
         default: begin
            steps_p = diff_e[POSITION_WIDTH-1:0];
         end
      endcase
   end

   // two toggles per microstep
   assign total = steps_p << k_here;

endmodule

/* src/sapc_axis_state.sv */
// Axis state, microstep register and per-item next-state logic.
module sapc_axis_state import sapc_pkg::*; #(
   parameter int POSITION_WIDTH = 32,
   parameter int STEP_WIDTH = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [SHIFT_WIDTH-1:0]  csr_write_data,
   input  logic                    fire,
   input  req_flags_type           flags,
   input  logic [STEP_WIDTH-1:0]   move_steps,
   input  logic [TARGET_WIDTH-1:0] target_position,
   output rsp_item_type            item_next
);

   localparam int P = POSITION_WIDTH;

   logic [SHIFT_WIDTH-1:0] shift_ff;
   logic                   pin_ff, pin_in;
   logic                   dir_ff, dir_in;
   logic                   active_ff, active_in;
   logic                   track_ff, track_in;
   logic [P-1:0]           done_ff, done_in;
   logic [P-1:0]           total_ff, total_in;
   logic [P-1:0]           cur_ff, cur_in;
   logic [P-1:0]           lmax_ff, lmax_in;
   logic [P-1:0]           goal_ff, goal_in;

   logic [P-1:0]           move_total;
   logic                   move_plus;
   logic [P-1:0]           mag;
   logic [P-1:0]           done_inc;
   logic [P-1:0]           cur_up, cur_dn;
   logic [63:0]            target_sx;
   logic [63:0]            cur_z, lmax_z;

   sapc_move_calc #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .STEP_WIDTH     (STEP_WIDTH)
   ) u_move_calc (
      .kind        (flags.kind),
      .move_steps  (move_steps),
      .shift       (shift_ff),
      .cur_pos     (cur_ff),
      .learned_max (lmax_ff),
      .total       (move_total)
   );

   // a zero-length move counts as minus
   assign move_plus = !move_total[P-1] && (move_total != '0);
   assign mag       = total_ff[P-1] ? ('0 - total_ff) : total_ff;
   assign done_inc  = done_ff + 1'b1;
   assign cur_up    = cur_ff + 1'b1;
   assign cur_dn    = cur_ff - 1'b1;
   assign target_sx = {{(64-TARGET_WIDTH){target_position[TARGET_WIDTH-1]}}, target_position};

   always_comb begin
      pin_in    = pin_ff;
      dir_in    = dir_ff;
      active_in = active_ff;
      track_in  = track_ff;
      done_in   = done_ff;
      total_in  = total_ff;
      cur_in    = cur_ff;
      lmax_in   = lmax_ff;
      goal_in   = goal_ff;
      case (flags.kind)
         KIND_TICK: begin
            if (active_ff && track_ff) begin
               if ($signed(cur_ff) < $signed(goal_ff)) begin
                  dir_in = 1'b1;
                  if (!flags.max_hit) begin
                     pin_in = ~pin_ff;
                     cur_in = cur_up;
                  end
               end else if ($signed(goal_ff) < $signed(cur_ff)) begin
                  dir_in = 1'b0;
                  if (!flags.min_hit) begin
                     pin_in = ~pin_ff;
                     cur_in = cur_dn;
                  end
               end
            end else if (active_ff) begin
               if (dir_ff && flags.max_hit) begin
                  active_in = 1'b0;
                  pin_in    = 1'b0;
                  lmax_in   = cur_ff;
               end else if (!dir_ff && flags.min_hit) begin
                  active_in = 1'b0;
                  pin_in    = 1'b0;
                  cur_in    = '0;
               end else begin
                  cur_in  = dir_ff ? cur_up : cur_dn;
                  done_in = done_inc;
                  if (done_inc >= mag) begin
                     active_in = 1'b0;
                     pin_in    = 1'b0;
                  end else begin
                     pin_in = ~pin_ff;
                  end
               end
            end
         end
         KIND_MOVE, KIND_HOME, KIND_CENTRE: begin
            track_in  = 1'b0;
            active_in = 1'b0;
            pin_in    = 1'b0;
            total_in  = move_total;
            dir_in    = move_plus;
            if (move_plus && flags.max_hit) begin
               // blocked at the maximum end
            end else if (!move_plus && flags.min_hit) begin
               cur_in = '0;
            end else begin
               done_in   = '0;
               active_in = 1'b1;
            end
         end
         KIND_SET_TARGET: begin
            goal_in = target_sx[P-1:0];
         end
         KIND_CONT_ON: begin
            if (!track_ff) begin
               track_in  = 1'b1;
               active_in = 1'b1;
               done_in   = '0;
               total_in  = '0;
            end
         end
         KIND_CONT_OFF: begin
            if (track_ff) begin
               track_in  = 1'b0;
               active_in = 1'b0;
            end
         end
         KIND_STOP: begin
            track_in  = 1'b0;
            active_in = 1'b0;
            pin_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_write_en) begin
         shift_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff    <= 1'b0;
         dir_ff    <= 1'b0;
         active_ff <= 1'b0;
         track_ff  <= 1'b0;
         done_ff   <= '0;
         total_ff  <= '0;
         cur_ff    <= '1;
         lmax_ff   <= '1;
         goal_ff   <= '0;
      end else if (fire) begin
         pin_ff    <= pin_in;
         dir_ff    <= dir_in;
         active_ff <= active_in;
         track_ff  <= track_in;
         done_ff   <= done_in;
         total_ff  <= total_in;
         cur_ff    <= cur_in;
         lmax_ff   <= lmax_in;
         goal_ff   <= goal_in;
      end
   end

   assign cur_z  = 64'(cur_in);
   assign lmax_z = 64'(lmax_in);

   always_comb begin
      item_next.step_level        = pin_in;
      item_next.direction_plus    = dir_in;
      item_next.moving            = active_in;
      item_next.continuous_active = track_in;
      item_next.position          = cur_z[OUT_POS_WIDTH-1:0];
      item_next.max_position      = lmax_z[OUT_POS_WIDTH-1:0];
   end

endmodule

/* src/sapc_out_reg.sv */
// Result register: holds one response until the receiver takes it.
module sapc_out_reg import sapc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item_in,
   output logic         out_free,
   sapc_rsp_if.source   rsp_ch
);

   logic         valid_ff;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign rsp_ch.valid             = valid_ff;
   assign rsp_ch.step_level        = item_ff.step_level;
   assign rsp_ch.direction_plus    = item_ff.direction_plus;
   assign rsp_ch.moving            = item_ff.moving;
   assign rsp_ch.continuous_active = item_ff.continuous_active;
   assign rsp_ch.position          = item_ff.position;
   assign rsp_ch.max_position      = item_ff.max_position;

endmodule

/* src/stepper_axis_pulse_controller_core.sv */
// Top level of the stepper axis step/direction pulse controller.
//
// Usage:
//   req_ch  : commands (tick, move, set target, continuous on/off, stop, home,
//             centre) with the two limit switch levels, valid/ready.
//   rsp_ch  : one response per command: step pin level, direction, moving,
//             continuous mode, position and learned maximum after the command.
//   csr_*   : write-only microstep shift register; write only while idle.
// Path: a transferred request is loaded into the input register, then into the
//   result register, which presents it on rsp_ch.
// Throughput: one command per cycle while rsp_ch.ready is high; the update is a
//   single pass of compare, increment and shift logic between the two registers.
// Reset: position and learned maximum read -1, motion and continuous mode off,
//   microstep shift 4, both channels empty.
// Stall: a response waits in the result register while rsp_ch.ready is low;
//   one more request is held in the input register, then req_ch.ready drops.
module stepper_axis_pulse_controller_core import sapc_pkg::*; #(
   parameter int POSITION_WIDTH = 32,
   parameter int STEP_WIDTH = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   sapc_req_if.sink               req_ch,
   sapc_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [SHIFT_WIDTH-1:0] csr_write_data
);

   logic                    item_valid;
   req_flags_type           flags;
   logic [STEP_WIDTH-1:0]   move_steps;
   logic [TARGET_WIDTH-1:0] target_position;
   logic                    out_free;
   logic                    fire;
   rsp_item_type            item_next;

   assign fire = item_valid && out_free;

   sapc_in_reg #(
      .STEP_WIDTH (STEP_WIDTH)
   ) u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .advance         (fire),
      .item_valid      (item_valid),
      .flags           (flags),
      .move_steps      (move_steps),
      .target_position (target_position)
   );

   sapc_axis_state #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .STEP_WIDTH     (STEP_WIDTH)
   ) u_axis_state (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .fire            (fire),
      .flags           (flags),
      .move_steps      (move_steps),
      .target_position (target_position),
      .item_next       (item_next)
   );

   sapc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .item_in  (item_next),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* src/sapc_checker.sv */
// Port-level checks for the pulse controller, bound to the top level.
module sapc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic moving,
   input logic continuous_active
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // with the sink ready, a request transfer is on the output after the next edge
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response late");

   a_cont_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && continuous_active |-> moving)
      else $error("continuous mode without active timer");

endmodule

bind stepper_axis_pulse_controller_core sapc_checker u_sapc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .moving            (rsp_ch.moving),
   .continuous_active (rsp_ch.continuous_active)
);
